// ===== hdl/hrhp_pkg.sv =====
// shared types, codes and character helpers for the http response header parser
package hrhp_pkg;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_DATA  = 2'd1,
    FN_EOS   = 2'd2,
    FN_NOP   = 2'd3
  } func_e;

  typedef enum logic [5:0] {
    PH_STATUS  = 6'b000001,
    PH_HEADERS = 6'b000010,
    PH_BODY    = 6'b000100,
    PH_DONE    = 6'b001000,
    PH_CLOSED  = 6'b010000,
    PH_BROKEN  = 6'b100000
  } phase_e;

  localparam logic [2:0] SC_STATUS  = 3'd0;
  localparam logic [2:0] SC_HEADERS = 3'd1;
  localparam logic [2:0] SC_BODY    = 3'd2;
  localparam logic [2:0] SC_DONE    = 3'd3;
  localparam logic [2:0] SC_CLOSED  = 3'd4;
  localparam logic [2:0] SC_BROKEN  = 3'd5;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [4:0] STATUS_LIT_LEN = 5'd7;
  localparam logic [4:0] LENGTH_LIT_LEN = 5'd16;

  localparam logic signed [16:0] STATUS_NONE = -17'sd1;
  localparam logic [15:0] STATUS_MAX = 16'hFFFF;

  typedef struct packed {
    phase_e              phase;
    logic                cr_pending;
    logic                line_nonempty;
    logic [4:0]          match_index;
    logic                match_ok;
    logic [2:0]          number_phase;
    logic signed [16:0]  status_value;
    logic                length_seen;
  } hrhp_state_t;

  localparam hrhp_state_t STATE_RESET = '{
    phase:         PH_STATUS,
    cr_pending:    1'b0,
    line_nonempty: 1'b0,
    match_index:   5'd0,
    match_ok:      1'b1,
    number_phase:  3'd0,
    status_value:  STATUS_NONE,
    length_seen:   1'b0
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [7:0] lit_status(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h48;
      3'd1:    r = 8'h54;
      3'd2:    r = 8'h54;
      3'd3:    r = 8'h50;
      3'd4:    r = 8'h2F;
      3'd5:    r = 8'h31;
      3'd6:    r = 8'h2E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] lit_length(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0:    r = 8'h43;
      4'd1:    r = 8'h6F;
      4'd2:    r = 8'h6E;
      4'd3:    r = 8'h74;
      4'd4:    r = 8'h65;
      4'd5:    r = 8'h6E;
      4'd6:    r = 8'h74;
      4'd7:    r = 8'h2D;
      4'd8:    r = 8'h4C;
      4'd9:    r = 8'h65;
      4'd10:   r = 8'h6E;
      4'd11:   r = 8'h67;
      4'd12:   r = 8'h74;
      4'd13:   r = 8'h68;
      4'd14:   r = 8'h3A;
      default: r = 8'h20;
    endcase
    return r;
  endfunction

  // a lone cr taken as line content
  function automatic hrhp_state_t cr_char(input hrhp_state_t s);
    hrhp_state_t r;
    r = s;
    r.line_nonempty = 1'b1;
    if (s.match_ok) begin
      unique case (s.number_phase)
        3'd0:    r.match_ok = 1'b0;
        3'd2:    r.number_phase = 3'd3;
        3'd4:    r.number_phase = 3'd5;
        default: r = r;
      endcase
    end
    return r;
  endfunction

  function automatic hrhp_state_t status_char(input hrhp_state_t s, input logic [7:0] c);
    hrhp_state_t r;
    logic [20:0] acc;
    r = s;
    acc = ({5'd0, s.status_value[15:0]} << 3) + ({5'd0, s.status_value[15:0]} << 1)
          + {17'd0, c[3:0]};
    if (s.match_ok) begin
      unique case (s.number_phase)
        3'd0: begin
          if ((s.match_index < STATUS_LIT_LEN) && (c == lit_status(s.match_index[2:0]))) begin
            r.match_index = s.match_index + 5'd1;
            if (r.match_index == STATUS_LIT_LEN) r.number_phase = 3'd1;
          end else begin
            r.match_ok = 1'b0;
          end
        end
        3'd1: begin
          if (is_digit(c)) r.number_phase = 3'd2;
          else if (!is_ws(c)) r.match_ok = 1'b0;
        end
        3'd2: begin
          if (is_ws(c)) r.number_phase = 3'd3;
          else if (!is_digit(c)) r.match_ok = 1'b0;
        end
        3'd3: begin
          if (is_digit(c)) begin
            r.number_phase = 3'd4;
            r.status_value = {13'd0, c[3:0]};
          end else if (!is_ws(c)) begin
            r.match_ok = 1'b0;
          end
        end
        3'd4: begin
          if (is_digit(c)) begin
            if (acc > {5'd0, STATUS_MAX}) r.status_value = {1'b0, STATUS_MAX};
            else r.status_value = {1'b0, acc[15:0]};
          end else begin
            r.number_phase = 3'd5;
          end
        end
        default: r = r;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== hdl/hrhp_in_if.sv =====
// input channel: command code and response byte with valid/ready
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface

// ===== hdl/hrhp_out_if.sv =====
// result channel: parse status and body pass-through with valid/ready
interface hrhp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         state_code;
  logic signed [16:0] resp_status;
  logic [31:0]        body_length;
  logic               length_known;
  logic               body_valid;
  logic [7:0]         body_byte;
  logic [31:0]        body_count;
  logic               need_more;

  modport source (
    output valid, output state_code, output resp_status, output body_length,
    output length_known, output body_valid, output body_byte, output body_count,
    output need_more, input ready
  );
  modport sink (
    input valid, input state_code, input resp_status, input body_length,
    input length_known, input body_valid, input body_byte, input body_count,
    input need_more, output ready
  );
endinterface

// ===== hdl/http_response_header_parser_unit.sv =====
// top level of the byte-serial http/1.x response header parser
// usage:
//   item_i carries one command per item: start a new response, one response
//   byte, end of stream or a no-op. result_o returns exactly one result per item with
//   the parse state, status, content length, the body byte when the byte
//   belongs to the body, and the body byte count.
//   path: an accepted item lands in the input register, and its result is
//   loaded from there into the output register, which drives result_o.valid.
//   throughput: one item per cycle unless result_o stalls; the per-byte work
//   is one literal compare and one multiply-by-ten add, done between the input
//   and result registers.
//   stall: while result_o.ready is low the result is held; one more item is
//   still taken into the input register, after which item_i.ready drops until
//   the result is taken.
//   reset: the parse returns to the status line phase with status -1, length
//   and body count zero, and both pipeline registers empty.
//   LENGTH_BITS sets the width of the length and body counters; both saturate
//   at all ones and are reported in their low 32 bits.
module http_response_header_parser_unit import hrhp_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hrhp_in_if.sink     item_i,
  hrhp_out_if.source  result_o
);

  logic                   s1_valid_q;
  logic [1:0]             s1_func_q;
  logic [7:0]             s1_byte_q;
  logic                   out_valid_q;
  logic                   adv;

  hrhp_state_t            st_q, st_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic                   body_valid;

  logic [2:0]             state_code_q;
  logic signed [16:0]     resp_status_q;
  logic [31:0]            body_length_q;
  logic                   has_len_q;
  logic                   body_valid_q;
  logic [7:0]             body_byte_q;
  logic [31:0]            body_count_q;
  logic                   need_more_q;

  logic [2:0]             code_d;
  logic [LENGTH_BITS+31:0] len_ext;
  logic [LENGTH_BITS+31:0] cnt_ext;

  assign adv = s1_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !s1_valid_q || adv;

  hrhp_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .cur_i        (st_q),
    .len_i        (len_q),
    .cnt_i        (cnt_q),
    .func_i       (s1_func_q),
    .data_byte_i  (s1_byte_q),
    .nxt_o        (st_d),
    .len_o        (len_d),
    .cnt_o        (cnt_d),
    .body_valid_o (body_valid)
  );

  always_comb begin
    unique case (st_d.phase)
      PH_STATUS:  code_d = SC_STATUS;
      PH_HEADERS: code_d = SC_HEADERS;
      PH_BODY:    code_d = SC_BODY;
      PH_DONE:    code_d = SC_DONE;
      PH_CLOSED:  code_d = SC_CLOSED;
      PH_BROKEN:  code_d = SC_BROKEN;
      default:    code_d = SC_BROKEN;
    endcase
  end

  assign len_ext = {32'd0, len_d};
  assign cnt_ext = {32'd0, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= STATE_RESET;
      len_q       <= '0;
      cnt_q       <= '0;
    end else begin
      if (item_i.ready) s1_valid_q <= item_i.valid;
      if (adv) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
        len_q       <= len_d;
        cnt_q       <= cnt_d;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      s1_func_q <= item_i.func;
      s1_byte_q <= item_i.data_byte;
    end
    if (adv) begin
      state_code_q     <= code_d;
      resp_status_q    <= (st_d.phase == PH_STATUS) ? STATUS_NONE : st_d.status_value;
      body_length_q    <= len_ext[31:0];
      has_len_q        <= st_d.length_seen;
      body_valid_q     <= body_valid;
      body_byte_q      <= body_valid ? s1_byte_q : 8'd0;
      body_count_q     <= cnt_ext[31:0];
      need_more_q      <= (st_d.phase == PH_STATUS) || (st_d.phase == PH_HEADERS) ||
                          (st_d.phase == PH_BODY);
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.state_code   = state_code_q;
  assign result_o.resp_status  = resp_status_q;
  assign result_o.body_length  = body_length_q;
  assign result_o.length_known = has_len_q;
  assign result_o.body_valid   = body_valid_q;
  assign result_o.body_byte    = body_byte_q;
  assign result_o.body_count   = body_count_q;
  assign result_o.need_more    = need_more_q;

  a_body_only_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && body_valid |-> st_q.phase == PH_BODY)
    else $error("body byte flagged outside body phase");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (s1_func_q != FN_START) |-> cnt_d >= cnt_q)
    else $error("body count decreased without a start item");

  a_headers_have_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_HEADERS |-> !st_q.status_value[16])
    else $error("header phase without a parsed status");

  a_final_phase_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (s1_func_q == FN_DATA) &&
    ((st_q.phase == PH_DONE) || (st_q.phase == PH_CLOSED) || (st_q.phase == PH_BROKEN))
    |=> st_q.phase == $past(st_q.phase))
    else $error("data byte changed a finished parse");

endmodule

// ===== hdl/hrhp_core.sv =====
// next-state logic of the parser for one item
module hrhp_core import hrhp_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  hrhp_state_t            cur_i,
  input  logic [LENGTH_BITS-1:0] len_i,
  input  logic [LENGTH_BITS-1:0] cnt_i,
  input  logic [1:0]             func_i,
  input  logic [7:0]             data_byte_i,
  output hrhp_state_t            nxt_o,
  output logic [LENGTH_BITS-1:0] len_o,
  output logic [LENGTH_BITS-1:0] cnt_o,
  output logic                   body_valid_o
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  hrhp_state_t            st;
  hrhp_state_t            pre;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] cnt;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [LENGTH_BITS+3:0] acc;
  logic                   have_char;
  logic [7:0]             c;

  assign c = data_byte_i;
  assign acc = ({4'd0, len_i} << 3) + ({4'd0, len_i} << 1) + {{LENGTH_BITS{1'b0}}, c[3:0]};
  assign cnt_inc = (cnt_i < LEN_MAX) ? cnt_i + 1'b1 : cnt_i;

  always_comb begin
    st = cur_i;
    pre = cur_i;
    len = len_i;
    cnt = cnt_i;
    body_valid_o = 1'b0;
    have_char = 1'b0;
    unique case (func_e'(func_i))
      FN_START: begin
        st = STATE_RESET;
        len = '0;
        cnt = '0;
      end
      FN_DATA: begin
        if ((cur_i.phase == PH_STATUS) || (cur_i.phase == PH_HEADERS)) begin
          have_char = 1'b1;
          if (cur_i.cr_pending) begin
            pre.cr_pending = 1'b0;
            if (c == CH_LF) begin
              have_char = 1'b0;
              // end of line
              if (cur_i.phase == PH_STATUS) begin
                if (cur_i.match_ok && (cur_i.number_phase >= 3'd4)) begin
                  pre.phase = PH_HEADERS;
                end else begin
                  pre.phase = PH_BROKEN;
                  pre.status_value = STATUS_NONE;
                end
              end else if (!cur_i.line_nonempty) begin
                pre.phase = (cur_i.length_seen && (cnt_i >= len_i)) ? PH_DONE : PH_BODY;
              end
              pre.line_nonempty = 1'b0;
              pre.match_index = 5'd0;
              pre.match_ok = 1'b1;
              pre.number_phase = 3'd0;
            end else begin
              pre = cr_char(pre);
            end
          end
          st = pre;
          if (have_char) begin
            if (c == CH_CR) begin
              st.cr_pending = 1'b1;
            end else begin
              st.line_nonempty = 1'b1;
              if (pre.phase == PH_STATUS) begin
                st = status_char(st, c);
              end else if (pre.match_ok) begin
                unique case (pre.number_phase)
                  3'd0: begin
                    if ((pre.match_index < LENGTH_LIT_LEN) &&
                        (c == lit_length(pre.match_index[3:0]))) begin
                      st.match_index = pre.match_index + 5'd1;
                      if (st.match_index == LENGTH_LIT_LEN) begin
                        st.number_phase = 3'd1;
                        st.length_seen = 1'b1;
                        len = '0;
                      end
                    end else begin
                      st.match_ok = 1'b0;
                    end
                  end
                  3'd1: begin
                    if (is_digit(c)) begin
                      st.number_phase = 3'd2;
                      len = {{(LENGTH_BITS-4){1'b0}}, c[3:0]};
                    end else if (!is_ws(c)) begin
                      st.number_phase = 3'd3;
                    end
                  end
                  3'd2: begin
                    if (is_digit(c)) begin
                      len = (acc > {4'd0, LEN_MAX}) ? LEN_MAX : acc[LENGTH_BITS-1:0];
                    end else begin
                      st.number_phase = 3'd3;
                    end
                  end
                  default: st = st;
                endcase
              end
            end
          end
        end else if (cur_i.phase == PH_BODY) begin
          body_valid_o = 1'b1;
          cnt = cnt_inc;
          if (cur_i.length_seen && (cnt_inc >= len_i)) st.phase = PH_DONE;
        end
      end
      FN_EOS: begin
        if (cur_i.phase == PH_STATUS) st.status_value = STATUS_NONE;
        if ((cur_i.phase == PH_DONE) || ((cur_i.phase == PH_BODY) && !cur_i.length_seen)) begin
          st.phase = PH_CLOSED;
        end else begin
          st.phase = PH_BROKEN;
        end
        st.cr_pending = 1'b0;
      end
      FN_NOP: st = cur_i;
    endcase
  end

  assign nxt_o = st;
  assign len_o = len;
  assign cnt_o = cnt;

endmodule
